// File: sv/mcr_pkg.sv
`timescale 1ns / 1ps
package mcr_pkg;

  localparam int MAX_RADIUS  = 31;
  localparam int COORD_BITS  = 8;
  localparam int RAD_IN_BITS = 5;
  localparam int COLOR_BITS  = 4;
  localparam int CNT_BITS    = 3;
  localparam int OFS_BITS    = $clog2(MAX_RADIUS + 1);
  localparam int SQ_BITS     = $clog2(MAX_RADIUS * MAX_RADIUS + 1);
  // decision terms reach about 2*r^3; keep headroom for the signed sums
  localparam int ACC_BITS    = $clog2(2 * MAX_RADIUS * MAX_RADIUS * MAX_RADIUS + 1) + 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COLOR_BITS-1:0] COLOR_RESET = COLOR_BITS'(6);
  localparam logic [CNT_BITS-1:0]   CNT_PAIR    = CNT_BITS'(2);
  localparam logic [CNT_BITS-1:0]   CNT_QUAD    = CNT_BITS'(4);

  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic [OFS_BITS-1:0]          ofs_t;
  typedef logic [SQ_BITS-1:0]           sq_t;
  typedef logic signed [ACC_BITS-1:0]   acc_t;
  typedef logic [COLOR_BITS-1:0]        color_t;

  typedef struct packed {
    coord_t                 center_x;
    coord_t                 center_y;
    logic [RAD_IN_BITS-1:0] radius;
  } cmd_t;

  typedef struct packed {
    coord_t              x_plus;
    coord_t              x_minus;
    coord_t              y_minus;
    coord_t              y_plus;
    logic [CNT_BITS-1:0] pixel_count;
    color_t              color;
    logic                last;
  } grp_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    ofs_t   rad;
    sq_t    rsq;
    acc_t   rcube;
  } job_t;

endpackage

// File: sv/midpoint_circle_rasterizer.sv
// Path: a command passes the two front registers and the queue to reach the
//   stepping unit; each pixel group then waits in the pending register until the next group or the finish step.
// Throughput: one pixel group per cycle from the single stepping unit while out_ready
//   does not hold the output; the unit takes a new command only when it is back in idle.
// Reset: rst_n is synchronous, active low; it empties the pipeline and queue
//   and sets the color register to 6.
`timescale 1ns / 1ps
module midpoint_circle_rasterizer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mcr_pkg::cmd_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output mcr_pkg::grp_t   out_data,
  input  logic            cfg_we,
  input  mcr_pkg::color_t cfg_data
);

  mcr_pkg::color_t color_r, color_nxt;
  logic            fj_valid, fj_ready;
  mcr_pkg::job_t   fj_data;
  logic            bj_valid, bj_ready;
  mcr_pkg::job_t   bj_data;

  assign color_nxt = cfg_we ? cfg_data : color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= mcr_pkg::COLOR_RESET;
    end else begin
      color_r <= color_nxt;
    end
  end

  mcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job_data  (fj_data)
  );

  mcr_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_data  (fj_data),
    .pop_valid  (bj_valid),
    .pop_ready  (bj_ready),
    .pop_data   (bj_data)
  );

  mcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (bj_valid),
    .job_ready (bj_ready),
    .job_data  (bj_data),
    .color     (color_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sv/mcr_front.sv
`timescale 1ns / 1ps
module mcr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mcr_pkg::cmd_t    in_data,
  output logic             job_valid,
  input  logic             job_ready,
  output mcr_pkg::job_t    job_data
);

  logic              a_valid_r, a_valid_nxt;
  mcr_pkg::coord_t   a_cx_r, a_cx_nxt;
  mcr_pkg::coord_t   a_cy_r, a_cy_nxt;
  mcr_pkg::ofs_t     a_rad_r, a_rad_nxt;
  mcr_pkg::sq_t      a_rsq_r, a_rsq_nxt;
  logic              b_valid_r, b_valid_nxt;
  mcr_pkg::job_t     job_r, job_nxt;
  logic              b_free, a_adv;
  mcr_pkg::ofs_t     rad_sat;

  assign b_free    = !b_valid_r || job_ready;
  assign a_adv     = a_valid_r && b_free;
  assign in_ready  = !a_valid_r || a_adv;
  assign job_valid = b_valid_r;
  assign job_data  = job_r;

  always_comb begin
    if (int'(in_data.radius) > mcr_pkg::MAX_RADIUS) begin
      rad_sat = mcr_pkg::ofs_t'(mcr_pkg::MAX_RADIUS);
    end else begin
      rad_sat = mcr_pkg::ofs_t'(in_data.radius);
    end
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    a_cx_nxt    = a_cx_r;
    a_cy_nxt    = a_cy_r;
    a_rad_nxt   = a_rad_r;
    a_rsq_nxt   = a_rsq_r;
    b_valid_nxt = b_valid_r;
    job_nxt     = job_r;
    if (b_free) begin
      b_valid_nxt = a_valid_r;
    end
    if (a_adv) begin
      job_nxt.cx    = a_cx_r;
      job_nxt.cy    = a_cy_r;
      job_nxt.rad   = a_rad_r;
      job_nxt.rsq   = a_rsq_r;
      job_nxt.rcube = mcr_pkg::acc_t'(mcr_pkg::acc_t'(a_rsq_r) * mcr_pkg::acc_t'(a_rad_r));
    end
    if (in_ready) begin
      a_valid_nxt = in_valid;
    end
    if (in_valid && in_ready) begin
      a_cx_nxt  = in_data.center_x;
      a_cy_nxt  = in_data.center_y;
      a_rad_nxt = rad_sat;
      a_rsq_nxt = mcr_pkg::sq_t'(mcr_pkg::acc_t'(rad_sat) * mcr_pkg::acc_t'(rad_sat));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_cx_r  <= a_cx_nxt;
    a_cy_r  <= a_cy_nxt;
    a_rad_r <= a_rad_nxt;
    a_rsq_r <= a_rsq_nxt;
    job_r   <= job_nxt;
  end

endmodule

// File: sv/mcr_fifo.sv
`timescale 1ns / 1ps
module mcr_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  mcr_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mcr_pkg::job_t pop_data
);

  localparam int PTR_BITS = (mcr_pkg::QUEUE_DEPTH > 1) ? $clog2(mcr_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(mcr_pkg::QUEUE_DEPTH + 1);

  mcr_pkg::job_t        mem_r [mcr_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 push, pop;

  assign push_ready = (cnt_r != CNT_W'(mcr_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    if (int'(p) == mcr_pkg::QUEUE_DEPTH - 1) begin
      return '0;
    end
    return PTR_BITS'(p + 1'b1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/mcr_back.sv
`timescale 1ns / 1ps
module mcr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  output logic            job_ready,
  input  mcr_pkg::job_t   job_data,
  input  mcr_pkg::color_t color,
  output logic            out_valid,
  input  logic            out_ready,
  output mcr_pkg::grp_t   out_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_VAX  = 3'd1;
  localparam logic [2:0] ST_UP   = 3'd2;
  localparam logic [2:0] ST_HAX  = 3'd3;
  localparam logic [2:0] ST_LO   = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  mcr_pkg::coord_t  cx_r, cx_nxt;
  mcr_pkg::coord_t  cy_r, cy_nxt;
  mcr_pkg::ofs_t    r_r, r_nxt;
  mcr_pkg::acc_t    rsq_r, rsq_nxt;
  mcr_pkg::acc_t    thi_r, thi_nxt;
  mcr_pkg::acc_t    a0_r, a0_nxt;
  mcr_pkg::ofs_t    u_r, u_nxt;
  mcr_pkg::ofs_t    v_r, v_nxt;
  mcr_pkg::acc_t    ag_r, ag_nxt;
  mcr_pkg::acc_t    as_r, as_nxt;
  mcr_pkg::acc_t    th_r, th_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  mcr_pkg::grp_t    pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  mcr_pkg::grp_t    out_data_r, out_data_nxt;

  logic             adv, produce, brk, dec;
  mcr_pkg::grp_t    grp;
  mcr_pkg::acc_t    rsq2, th1, th2, as1, ag1;
  mcr_pkg::ofs_t    u1, v1;
  mcr_pkg::ofs_t    ofs_x, ofs_y;

  assign job_ready = (state_r == ST_IDLE);
  assign adv       = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign rsq2      = mcr_pkg::acc_t'(rsq_r <<< 1);

  // one midpoint step; u grows, v shrinks when the decision term is non-negative, roles of x and y swap per region
  always_comb begin
    th1 = mcr_pkg::acc_t'(th_r + ag_r + rsq_r);
    dec = !th1[mcr_pkg::ACC_BITS-1];
    as1 = dec ? mcr_pkg::acc_t'(as_r - rsq2) : as_r;
    th2 = dec ? mcr_pkg::acc_t'(th1 - as1) : th1;
    v1  = dec ? mcr_pkg::ofs_t'(v_r - 1'b1) : v_r;
    ag1 = mcr_pkg::acc_t'(ag_r + rsq2);
    u1  = mcr_pkg::ofs_t'(u_r + 1'b1);
    if (state_r == ST_UP) begin
      brk = (ag1 >= as1);
    end else begin
      brk = (ag1 > as1);
    end
  end

  always_comb begin
    produce = 1'b0;
    ofs_x   = '0;
    ofs_y   = '0;
    grp.pixel_count = mcr_pkg::CNT_PAIR;
    case (state_r)
      ST_VAX: begin
        produce = 1'b1;
        ofs_y   = r_r;
      end
      ST_UP: begin
        produce = !brk;
        ofs_x   = u1;
        ofs_y   = v1;
        grp.pixel_count = mcr_pkg::CNT_QUAD;
      end
      ST_HAX: begin
        produce = 1'b1;
        ofs_x   = r_r;
      end
      ST_LO: begin
        produce = !brk;
        ofs_x   = v1;
        ofs_y   = u1;
        grp.pixel_count = mcr_pkg::CNT_QUAD;
      end
      default: begin
        produce = 1'b0;
      end
    endcase
    grp.x_plus  = mcr_pkg::coord_t'(cx_r + mcr_pkg::coord_t'(ofs_x));
    grp.x_minus = mcr_pkg::coord_t'(cx_r - mcr_pkg::coord_t'(ofs_x));
    grp.y_minus = mcr_pkg::coord_t'(cy_r - mcr_pkg::coord_t'(ofs_y));
    grp.y_plus  = mcr_pkg::coord_t'(cy_r + mcr_pkg::coord_t'(ofs_y));
    grp.color   = color;
    grp.last    = 1'b0;
  end

  always_comb begin
    state_nxt      = state_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    r_nxt          = r_r;
    rsq_nxt        = rsq_r;
    thi_nxt        = thi_r;
    a0_nxt         = a0_r;
    u_nxt          = u_r;
    v_nxt          = v_r;
    ag_nxt         = ag_r;
    as_nxt         = as_r;
    th_nxt         = th_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    if (state_r == ST_IDLE) begin
      if (job_valid) begin
        cx_nxt    = job_data.cx;
        cy_nxt    = job_data.cy;
        r_nxt     = job_data.rad;
        rsq_nxt   = mcr_pkg::acc_t'(job_data.rsq);
        thi_nxt   = mcr_pkg::acc_t'(mcr_pkg::acc_t'(job_data.rsq >> 2) - job_data.rcube);
        a0_nxt    = mcr_pkg::acc_t'(job_data.rcube <<< 1);
        state_nxt = ST_VAX;
      end
    end else if (adv) begin
      // hold each group back until the next is produced so the final one can carry last
      if (produce) begin
        if (pend_valid_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pend_r;
        end
        pend_valid_nxt = 1'b1;
        pend_nxt       = grp;
      end
      case (state_r)
        ST_VAX, ST_HAX: begin
          u_nxt  = '0;
          v_nxt  = r_r;
          ag_nxt = '0;
          as_nxt = a0_r;
          th_nxt = thi_r;
          if (r_r == '0) begin
            state_nxt = (state_r == ST_VAX) ? ST_HAX : ST_FIN;
          end else begin
            state_nxt = (state_r == ST_VAX) ? ST_UP : ST_LO;
          end
        end
        ST_UP, ST_LO: begin
          if (brk) begin
            state_nxt = (state_r == ST_UP) ? ST_HAX : ST_FIN;
          end else begin
            u_nxt  = u1;
            v_nxt  = v1;
            ag_nxt = ag1;
            as_nxt = as1;
            th_nxt = th2;
          end
        end
        ST_FIN: begin
          out_valid_nxt     = 1'b1;
          out_data_nxt      = pend_r;
          out_data_nxt.last = 1'b1;
          pend_valid_nxt    = 1'b0;
          state_nxt         = ST_IDLE;
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    r_r        <= r_nxt;
    rsq_r      <= rsq_nxt;
    thi_r      <= thi_nxt;
    a0_r       <= a0_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    ag_r       <= ag_nxt;
    as_r       <= as_nxt;
    th_r       <= th_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  a_job_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job_ready |-> !pend_valid_r)
    else $error("job taken while a group is still held");

  a_fin_has_group: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |-> pend_valid_r)
    else $error("finish step without a held group");

  a_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pend_valid_r))
    else $error("output loaded without a held group");

  a_count_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.pixel_count == mcr_pkg::CNT_PAIR ||
                     out_data_r.pixel_count == mcr_pkg::CNT_QUAD))
    else $error("bad pixel count on output");

endmodule
